// ===== rtl/core/mht_pkg.sv =====
// mht_pkg: shared widths, micro-op codes and control/status structs for the
// MACD histogram tracker. No dependencies; imported by every core module.
`timescale 1ns / 1ps
`default_nettype none

package mht_pkg;

  // Item field widths
  localparam int PRICE_W = 32;
  localparam int MACD_W  = 33;
  localparam int HIST_W  = 34;

  // Internal number formats: averages Q16.24, seed sums Q16.16
  localparam int AVG_W  = 44;
  localparam int SUM_W  = 40;
  localparam int OPND_W = AVG_W;

  // Constant multiplier: 24-bit Q0.24 constant, operand split at bit 24
  localparam int MC_W  = 24;
  localparam int LO_W  = 24;
  localparam int HI_W  = OPND_W - LO_W;
  localparam int PLO_W = 2 * MC_W + 1;
  localparam int PHI_W = HI_W + MC_W + 1;

  // Rounding shifts: seed mean drops 16 bits, average update drops 24,
  // Q16.24 to Q16.16 drops 8
  localparam int SEED_SHIFT = 16;
  localparam int EMA_SHIFT  = 24;
  localparam int FRAC_DROP  = 8;

  // Microcode program counter
  localparam int PC_W = 4;

  typedef enum logic [1:0] {
    CH_FAST = 2'd0,
    CH_SLOW = 2'd1,
    CH_SIG  = 2'd2
  } ch_t;

  typedef enum logic [3:0] {
    OP_NOP      = 4'd0,
    OP_LOAD     = 4'd1,
    OP_SUM_ADD  = 4'd2,
    OP_MUL_LO   = 4'd3,
    OP_MUL_HI   = 4'd4,
    OP_SEED_WB  = 4'd5,
    OP_DIFF     = 4'd6,
    OP_EMA_WB   = 4'd7,
    OP_NEXT_CH  = 4'd8,
    OP_MACD_PRE = 4'd9,
    OP_MACD_WB  = 4'd10,
    OP_HIST_PRE = 4'd11,
    OP_OUT_WB   = 4'd12
  } op_t;

  typedef enum logic [3:0] {
    COND_NEXT          = 4'd0,
    COND_ALWAYS        = 4'd1,
    COND_WAIT_IN       = 4'd2,
    COND_WAIT_OUT      = 4'd3,
    COND_EMA_PHASE     = 4'd4,
    COND_NOT_SEED_END  = 4'd5,
    COND_CH_FAST       = 4'd6,
    COND_CH_SIG        = 4'd7,
    COND_NO_MACD       = 4'd8,
    COND_NO_RESULT     = 4'd9
  } cond_t;

  // Sequencer to datapath
  typedef struct packed {
    op_t  op;
    logic seed;   // 1: seed reciprocal and 16-bit rounding, 0: average weight
    logic en;     // op takes effect this cycle
    logic idle;   // waiting for an item
  } ctl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic ema_phase;
    logic seed_end;
    logic ch_fast;
    logic ch_sig;
    logic no_macd;
    logic no_result;
    logic out_full;
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/mht_sequencer.sv =====
// mht_sequencer: microcode ROM, step counter and branch logic.
// Depends on mht_pkg for op/cond codes and the ctl_t / stat_t structs.
`timescale 1ns / 1ps
`default_nettype none

module mht_sequencer (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire mht_pkg::stat_t stat,
  output mht_pkg::ctl_t       ctl
);
  import mht_pkg::*;

  typedef struct packed {
    op_t              op;
    logic             seed;
    cond_t            cond;
    logic [PC_W-1:0]  tgt;
  } uword_t;

  // Program addresses
  localparam logic [PC_W-1:0] PC_IDLE     = 4'd0;
  localparam logic [PC_W-1:0] PC_TRACK    = 4'd1;
  localparam logic [PC_W-1:0] PC_SEED_ADD = 4'd2;
  localparam logic [PC_W-1:0] PC_SEED_LO  = 4'd3;
  localparam logic [PC_W-1:0] PC_SEED_HI  = 4'd4;
  localparam logic [PC_W-1:0] PC_SEED_WB  = 4'd5;
  localparam logic [PC_W-1:0] PC_EMA_DIFF = 4'd6;
  localparam logic [PC_W-1:0] PC_EMA_LO   = 4'd7;
  localparam logic [PC_W-1:0] PC_EMA_HI   = 4'd8;
  localparam logic [PC_W-1:0] PC_EMA_WB   = 4'd9;
  localparam logic [PC_W-1:0] PC_CH_END   = 4'd10;
  localparam logic [PC_W-1:0] PC_DISPATCH = 4'd11;
  localparam logic [PC_W-1:0] PC_MACD_PRE = 4'd12;
  localparam logic [PC_W-1:0] PC_MACD_WB  = 4'd13;
  localparam logic [PC_W-1:0] PC_HIST_PRE = 4'd14;
  localparam logic [PC_W-1:0] PC_OUT      = 4'd15;

  // Control store. The track routine (PC_TRACK..PC_CH_END) runs once per
  // average, on the channel held in the datapath.
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{OP_NOP, 1'b0, COND_ALWAYS, PC_IDLE};
    unique case (pc)
      PC_IDLE:     w = '{OP_LOAD,     1'b0, COND_WAIT_IN,      PC_IDLE};
      PC_TRACK:    w = '{OP_NOP,      1'b0, COND_EMA_PHASE,    PC_EMA_DIFF};
      PC_SEED_ADD: w = '{OP_SUM_ADD,  1'b0, COND_NOT_SEED_END, PC_CH_END};
      PC_SEED_LO:  w = '{OP_MUL_LO,   1'b1, COND_NEXT,         PC_IDLE};
      PC_SEED_HI:  w = '{OP_MUL_HI,   1'b1, COND_NEXT,         PC_IDLE};
      PC_SEED_WB:  w = '{OP_SEED_WB,  1'b1, COND_ALWAYS,       PC_CH_END};
      PC_EMA_DIFF: w = '{OP_DIFF,     1'b0, COND_NEXT,         PC_IDLE};
      PC_EMA_LO:   w = '{OP_MUL_LO,   1'b0, COND_NEXT,         PC_IDLE};
      PC_EMA_HI:   w = '{OP_MUL_HI,   1'b0, COND_NEXT,         PC_IDLE};
      PC_EMA_WB:   w = '{OP_EMA_WB,   1'b0, COND_NEXT,         PC_IDLE};
      PC_CH_END:   w = '{OP_NEXT_CH,  1'b0, COND_CH_FAST,      PC_TRACK};
      PC_DISPATCH: w = '{OP_NOP,      1'b0, COND_CH_SIG,       PC_HIST_PRE};
      PC_MACD_PRE: w = '{OP_MACD_PRE, 1'b0, COND_NO_MACD,      PC_IDLE};
      PC_MACD_WB:  w = '{OP_MACD_WB,  1'b0, COND_ALWAYS,       PC_TRACK};
      PC_HIST_PRE: w = '{OP_HIST_PRE, 1'b0, COND_NO_RESULT,    PC_IDLE};
      // last step: falling through wraps the counter back to idle
      PC_OUT:      w = '{OP_OUT_WB,   1'b0, COND_WAIT_OUT,     PC_OUT};
      default:     w = '{OP_NOP,      1'b0, COND_ALWAYS,       PC_IDLE};
    endcase
    return w;
  endfunction

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  uword_t          word;
  logic            take;
  logic            hold;

  // Branch decision and control word
  always_comb begin
    word = ucode(pc_r);
    unique case (word.cond)
      COND_NEXT:         take = 1'b0;
      COND_ALWAYS:       take = 1'b1;
      COND_WAIT_IN:      take = !in_valid;
      COND_WAIT_OUT:     take = stat.out_full;
      COND_EMA_PHASE:    take = stat.ema_phase;
      COND_NOT_SEED_END: take = !stat.seed_end;
      COND_CH_FAST:      take = stat.ch_fast;
      COND_CH_SIG:       take = stat.ch_sig;
      COND_NO_MACD:      take = stat.no_macd;
      COND_NO_RESULT:    take = stat.no_result;
      default:           take = 1'b0;
    endcase
    // a taken wait branch suppresses the step's op
    hold     = take && (word.cond inside {COND_WAIT_IN, COND_WAIT_OUT});
    pc_nxt   = take ? word.tgt : pc_r + PC_W'(1);
    ctl.op   = word.op;
    ctl.seed = word.seed;
    ctl.en   = !hold;
    ctl.idle = (pc_r == PC_IDLE);
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mht_datapath.sv =====
// mht_datapath: average/sum registers, shared 24-bit constant multiplier,
// sample counter and output register. Depends on mht_pkg; driven by mht_sequencer.
`timescale 1ns / 1ps
`default_nettype none

module mht_datapath #(
  parameter int FAST_PERIOD   = 12,
  parameter int SLOW_PERIOD   = 26,
  parameter int SIGNAL_PERIOD = 9
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire mht_pkg::ctl_t                     ctl,
  output mht_pkg::stat_t                         stat,
  input  wire logic [mht_pkg::PRICE_W-1:0]       in_price,
  input  wire logic                              in_restart,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [mht_pkg::HIST_W-1:0]      out_histogram,
  output logic signed [mht_pkg::MACD_W-1:0]      out_macd_value,
  output logic                                   out_buy
);
  import mht_pkg::*;

  localparam int MACD_START = (FAST_PERIOD > SLOW_PERIOD) ? FAST_PERIOD : SLOW_PERIOD;
  localparam int COUNT_CAP  = MACD_START + SIGNAL_PERIOD - 1;
  localparam int CNT_W      = $clog2(MACD_START + SIGNAL_PERIOD + 1);
  localparam int NUM_CH     = 3;
  localparam int Q_W        = OPND_W - FRAC_DROP;

  localparam logic [CNT_W-1:0] FAST_P   = CNT_W'(FAST_PERIOD);
  localparam logic [CNT_W-1:0] SLOW_P   = CNT_W'(SLOW_PERIOD);
  localparam logic [CNT_W-1:0] SIG_P    = CNT_W'(SIGNAL_PERIOD);
  localparam logic [CNT_W-1:0] START_K  = CNT_W'(MACD_START);
  localparam logic [CNT_W-1:0] SIG_OFS  = CNT_W'(MACD_START - 1);
  localparam logic [CNT_W-1:0] CAP_K    = CNT_W'(COUNT_CAP);

  // Q0.24 constants: seed reciprocal 1/P and average weight 2/(P+1)
  localparam logic [MC_W-1:0] FAST_RECIP =
    MC_W'((2**MC_W + FAST_PERIOD / 2) / FAST_PERIOD);
  localparam logic [MC_W-1:0] SLOW_RECIP =
    MC_W'((2**MC_W + SLOW_PERIOD / 2) / SLOW_PERIOD);
  localparam logic [MC_W-1:0] SIG_RECIP =
    MC_W'((2**MC_W + SIGNAL_PERIOD / 2) / SIGNAL_PERIOD);
  localparam logic [MC_W-1:0] FAST_WEIGHT =
    MC_W'((2**(MC_W + 1) + (FAST_PERIOD + 1) / 2) / (FAST_PERIOD + 1));
  localparam logic [MC_W-1:0] SLOW_WEIGHT =
    MC_W'((2**(MC_W + 1) + (SLOW_PERIOD + 1) / 2) / (SLOW_PERIOD + 1));
  localparam logic [MC_W-1:0] SIG_WEIGHT =
    MC_W'((2**(MC_W + 1) + (SIGNAL_PERIOD + 1) / 2) / (SIGNAL_PERIOD + 1));

  localparam logic [PLO_W-1:0]  SEED_RND = PLO_W'(1) << (SEED_SHIFT - 1);
  localparam logic [PLO_W-1:0]  EMA_RND  = PLO_W'(1) << (EMA_SHIFT - 1);
  localparam logic [OPND_W-1:0] Q16_RND  = OPND_W'(1) << (FRAC_DROP - 1);

  // Saturate a Q16.16 value to the MACD field
  function automatic logic [MACD_W-1:0] sat_macd(input logic [Q_W-1:0] v);
    logic [MACD_W-1:0] r;
    if (&v[Q_W-1:MACD_W-1] || ~|v[Q_W-1:MACD_W-1]) begin
      r = v[MACD_W-1:0];
    end else if (v[Q_W-1]) begin
      r = {1'b1, {(MACD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(MACD_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Saturate a Q17.16 difference to the histogram field
  function automatic logic [HIST_W-1:0] sat_hist(input logic [Q_W:0] v);
    logic [HIST_W-1:0] r;
    if (&v[Q_W:HIST_W-1] || ~|v[Q_W:HIST_W-1]) begin
      r = v[HIST_W-1:0];
    end else if (v[Q_W]) begin
      r = {1'b1, {(HIST_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(HIST_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Control registers
  logic [CNT_W-1:0] count_r, count_nxt;
  ch_t              ch_r, ch_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Payload registers
  logic [CNT_W-1:0]         k_r;
  logic [MACD_W-1:0]        x_r;
  logic [MACD_W-1:0]        macd_r;
  logic [OPND_W-1:0]        opnd_r;
  logic [PLO_W-1:0]         plo_r;
  logic signed [PHI_W-1:0]  phi_r;
  logic [AVG_W-1:0]         avg_r [NUM_CH];
  logic [SUM_W-1:0]         sum_r [NUM_CH];
  logic [HIST_W-1:0]        hist_r;
  logic [MACD_W-1:0]        omacd_r;
  logic                     buy_r;

  // Per-channel selection
  logic [CNT_W-1:0]         k_load;
  logic [CNT_W-1:0]         kk;
  logic [CNT_W-1:0]         period;
  logic [MC_W-1:0]          mconst;
  logic [AVG_W-1:0]         avg_cur;
  logic [SUM_W-1:0]         sum_new;
  logic [OPND_W-1:0]        x_sh;
  logic [2*MC_W-1:0]        lo_prod;
  logic signed [PHI_W-1:0]  hi_prod;
  logic [Q_W-1:0]           q_val;
  logic [Q_W:0]             hist_raw;
  logic [MACD_W-1:0]        macd_sat;
  logic [HIST_W-1:0]        hist_sat;
  logic                     out_full;

  assign k_load = (in_restart ? '0 : count_r) + CNT_W'(1);

  always_comb begin
    case (ch_r)
      CH_FAST: begin
        kk     = k_r;
        period = FAST_P;
        mconst = ctl.seed ? FAST_RECIP : FAST_WEIGHT;
      end
      CH_SLOW: begin
        kk     = k_r;
        period = SLOW_P;
        mconst = ctl.seed ? SLOW_RECIP : SLOW_WEIGHT;
      end
      CH_SIG: begin
        kk     = k_r - SIG_OFS;
        period = SIG_P;
        mconst = ctl.seed ? SIG_RECIP : SIG_WEIGHT;
      end
      default: begin
        kk     = k_r;
        period = FAST_P;
        mconst = FAST_WEIGHT;
      end
    endcase
  end

  assign avg_cur = avg_r[ch_r];

  // Seed sum: the first sample of a channel starts a new sum
  assign sum_new = ((kk == CNT_W'(1)) ? '0 : sum_r[ch_r])
                 + {{(SUM_W-MACD_W){x_r[MACD_W-1]}}, x_r};

  // Sample moved to Q16.24
  assign x_sh = {{(OPND_W-MACD_W-FRAC_DROP){x_r[MACD_W-1]}}, x_r, {FRAC_DROP{1'b0}}};

  // Partial products of the shared constant multiplier
  assign lo_prod = opnd_r[LO_W-1:0] * mconst;
  assign hi_prod = $signed(opnd_r[OPND_W-1:LO_W]) * $signed({1'b0, mconst});

  // Q16.24 to Q16.16 (rounding offset already added) and saturation
  assign q_val    = opnd_r[OPND_W-1:FRAC_DROP];
  assign macd_sat = sat_macd(q_val);
  assign hist_raw = {{(Q_W+1-MACD_W){macd_r[MACD_W-1]}}, macd_r} - {q_val[Q_W-1], q_val};
  assign hist_sat = sat_hist(hist_raw);

  assign out_full = out_valid_r && out_stall;

  // Status for branching
  always_comb begin
    stat.ema_phase = (kk > period);
    stat.seed_end  = (kk == period);
    stat.ch_fast   = (ch_r == CH_FAST);
    stat.ch_sig    = (ch_r == CH_SIG);
    stat.no_macd   = (k_r < START_K);
    stat.no_result = (k_r < CAP_K);
    stat.out_full  = out_full;
  end

  // Next values of control registers
  always_comb begin
    count_nxt     = count_r;
    ch_nxt        = ch_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (ctl.en) begin
      unique case (ctl.op)
        OP_LOAD: begin
          count_nxt = (k_load > CAP_K) ? CAP_K : k_load;
          ch_nxt    = CH_FAST;
        end
        OP_NEXT_CH: begin
          if (ch_r == CH_FAST) begin
            ch_nxt = CH_SLOW;
          end
        end
        OP_MACD_WB: ch_nxt = CH_SIG;
        OP_OUT_WB:  out_valid_nxt = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ch_r        <= CH_FAST;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath operations
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      unique case (ctl.op)
        OP_LOAD: begin
          k_r <= k_load;
          x_r <= {1'b0, in_price};
        end
        OP_SUM_ADD: begin
          sum_r[ch_r] <= sum_new;
          opnd_r      <= {{(OPND_W-SUM_W){sum_new[SUM_W-1]}}, sum_new};
        end
        OP_MUL_LO:  plo_r <= PLO_W'(lo_prod) + (ctl.seed ? SEED_RND : EMA_RND);
        OP_MUL_HI:  phi_r <= hi_prod;
        OP_SEED_WB: begin
          avg_r[ch_r] <= AVG_W'({phi_r, {(EMA_SHIFT-SEED_SHIFT){1'b0}}})
                       + AVG_W'(plo_r[PLO_W-1:SEED_SHIFT]);
        end
        OP_DIFF:    opnd_r <= x_sh - avg_cur;
        OP_EMA_WB: begin
          avg_r[ch_r] <= avg_cur + phi_r[AVG_W-1:0] + AVG_W'(plo_r[PLO_W-1:EMA_SHIFT]);
        end
        OP_MACD_PRE: opnd_r <= avg_r[CH_FAST] - avg_r[CH_SLOW] + Q16_RND;
        OP_MACD_WB: begin
          macd_r <= macd_sat;
          x_r    <= macd_sat;
        end
        OP_HIST_PRE: opnd_r <= avg_r[CH_SIG] + Q16_RND;
        OP_OUT_WB: begin
          hist_r  <= hist_sat;
          omacd_r <= macd_r;
          buy_r   <= !hist_sat[HIST_W-1] && (|hist_sat);
        end
        default: ;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_histogram  = hist_r;
  assign out_macd_value = omacd_r;
  assign out_buy        = buy_r;

endmodule

`default_nettype wire

// ===== rtl/core/macd_histogram_tracker_core.sv =====
// macd_histogram_tracker_core: top level of the MACD histogram tracker.
// Depends on mht_pkg, mht_sequencer and mht_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Tracks fast, slow and signal exponential averages of a Q16.16 price stream
// and emits one item (histogram, MACD, buy flag) per price once the signal
// average is seeded; warm-up prices produce nothing. A price with restart set
// starts a fresh warm-up at that price. For each item a microcoded program
// walks the three averages one after another through a pair of small constant
// multipliers (24 x 24 for the low operand half, 20 x 25 signed for the high
// half), one partial product per step, plus a few steps for MACD and histogram.
// The result sits in an output register, so the next price is accepted while
// it waits; the program only pauses on its last step if the previous result
// has still not been taken. No clearing pass is needed after reset.
module macd_histogram_tracker_core #(
  parameter int FAST_PERIOD   = 12,
  parameter int SLOW_PERIOD   = 26,
  parameter int SIGNAL_PERIOD = 9
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [mht_pkg::PRICE_W-1:0]   in_price,
  input  wire logic                          in_restart,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [mht_pkg::HIST_W-1:0]  out_histogram,
  output logic signed [mht_pkg::MACD_W-1:0]  out_macd_value,
  output logic                               out_buy
);
  import mht_pkg::*;

  ctl_t  ctl;
  stat_t stat;

  // Program sequencer
  mht_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .ctl      (ctl)
  );

  // Arithmetic and state
  mht_datapath #(
    .FAST_PERIOD   (FAST_PERIOD),
    .SLOW_PERIOD   (SLOW_PERIOD),
    .SIGNAL_PERIOD (SIGNAL_PERIOD)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .stat           (stat),
    .in_price       (in_price),
    .in_restart     (in_restart),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_histogram  (out_histogram),
    .out_macd_value (out_macd_value),
    .out_buy        (out_buy)
  );

  // Items are taken only while the program waits at its idle step
  assign in_stall = !ctl.idle;

  // An accepted item keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted on consecutive cycles");

  // A new result only appears at the end of a program run
  a_result_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an item in work");

  // Buy flag agrees with the histogram sign
  a_buy_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_buy == (out_histogram > 0)))
    else $error("buy flag does not match histogram");

endmodule

`default_nettype wire

// ===== test/macd_histogram_tracker_core_tb.sv =====
// macd_histogram_tracker_core_tb: self-checking bench for the MACD histogram tracker.
// Needs mht_pkg and macd_histogram_tracker_core. A built-in 12/26/9 MACD predictor
// checks every histogram item under random idle, stall and back-pressure.
`timescale 1ns / 1ps

module macd_histogram_tracker_core_tb;
  import mht_pkg::*;

  localparam int FAST_PERIOD   = 12;
  localparam int SLOW_PERIOD   = 26;
  localparam int SIGNAL_PERIOD = 9;
  localparam int MACD_START    = (FAST_PERIOD > SLOW_PERIOD) ? FAST_PERIOD : SLOW_PERIOD;
  localparam int COUNT_CAP     = MACD_START + SIGNAL_PERIOD - 1;

  // Q0.24 seed reciprocals and average weights, rounded to nearest
  localparam longint FAST_RECIP  = (64'sd16777216 + FAST_PERIOD / 2) / FAST_PERIOD;
  localparam longint SLOW_RECIP  = (64'sd16777216 + SLOW_PERIOD / 2) / SLOW_PERIOD;
  localparam longint SIG_RECIP   = (64'sd16777216 + SIGNAL_PERIOD / 2) / SIGNAL_PERIOD;
  localparam longint FAST_WEIGHT = (64'sd33554432 + (FAST_PERIOD + 1) / 2) / (FAST_PERIOD + 1);
  localparam longint SLOW_WEIGHT = (64'sd33554432 + (SLOW_PERIOD + 1) / 2) / (SLOW_PERIOD + 1);
  localparam longint SIG_WEIGHT  =
    (64'sd33554432 + (SIGNAL_PERIOD + 1) / 2) / (SIGNAL_PERIOD + 1);

  localparam longint MACD_MAX = 64'sd4294967295;
  localparam longint MACD_MIN = -64'sd4294967296;
  localparam longint HIST_MAX = 64'sd8589934591;
  localparam longint HIST_MIN = -64'sd8589934592;

  localparam longint PRICE_TOP = 64'sd4294967295;

  typedef struct {
    logic signed [HIST_W-1:0] hist;
    logic signed [MACD_W-1:0] macd;
    logic                     buy;
  } macd_result_t;

  typedef enum int {
    STYLE_SCATTER = 0,
    STYLE_WALK    = 1,
    STYLE_EXTREME = 2,
    STYLE_TREND   = 3
  } price_style_t;

  // Predictor of the tracker plus the queue of histogram items still owed
  class macd_outlook;
    int unsigned  seen;
    longint       avg[3];
    longint       seed_sum[3];
    macd_result_t pending_results[$];
    int           fails;

    function new();
      fails = 0;
      restart_state();
    endfunction

    function void restart_state();
      seen = 0;
      foreach (avg[i]) begin
        avg[i]      = 0;
        seed_sum[i] = 0;
      end
    endfunction

    // floor((x + 2^(s-1)) / 2^s), ties toward plus infinity
    function longint round_shr(longint x, int s);
      return (x + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function longint clamp(longint x, longint lo, longint hi);
      return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    // round_half_up(d * m / 2^24), product kept in 128 bits
    function longint scale_q24(longint d, longint m);
      logic signed [127:0] wide_d;
      logic signed [127:0] wide_m;
      logic signed [127:0] prod;
      wide_d = d;
      wide_m = m;
      prod   = wide_d * wide_m + 128'sh800000;
      prod   = prod >>> EMA_SHIFT;
      return longint'(prod);
    endfunction

    // Seed with the mean of the first samples, then run the exponential update
    function void advance(ch_t ch, int unsigned k, int unsigned period, longint x16,
                          longint recip, longint weight);
      if (k <= period) begin
        seed_sum[ch] += x16;
        if (k == period) avg[ch] = round_shr(seed_sum[ch] * recip, SEED_SHIFT);
      end else begin
        avg[ch] += scale_q24(x16 * 256 - avg[ch], weight);
      end
    endfunction

    function void take_price(logic [PRICE_W-1:0] price, logic restart);
      int unsigned  k;
      int unsigned  m;
      longint       x16;
      longint       macd;
      longint       hist;
      macd_result_t res;
      if (restart) restart_state();
      x16 = price;
      k   = seen + 1;
      advance(CH_FAST, k, FAST_PERIOD, x16, FAST_RECIP, FAST_WEIGHT);
      advance(CH_SLOW, k, SLOW_PERIOD, x16, SLOW_RECIP, SLOW_WEIGHT);
      seen = (k > COUNT_CAP) ? COUNT_CAP : k;
      if (k < MACD_START) return;

      // MACD feeds the signal average; output only once the signal is seeded
      macd = clamp(round_shr(avg[CH_FAST] - avg[CH_SLOW], FRAC_DROP), MACD_MIN, MACD_MAX);
      m    = k - MACD_START + 1;
      advance(CH_SIG, m, SIGNAL_PERIOD, macd, SIG_RECIP, SIG_WEIGHT);
      if (m < SIGNAL_PERIOD) return;

      hist     = clamp(macd - round_shr(avg[CH_SIG], FRAC_DROP), HIST_MIN, HIST_MAX);
      res.hist = hist[HIST_W-1:0];
      res.macd = macd[MACD_W-1:0];
      res.buy  = (hist > 0);
      pending_results.insert(pending_results.size(), res);
    endfunction

    task mismatch(string what);
      fails++;
      $display("ERROR at %0t ns: %s", $time, what);
    endtask

    task check_result(logic signed [HIST_W-1:0] hist, logic signed [MACD_W-1:0] macd,
                      logic buy);
      macd_result_t want;
      if (pending_results.size() == 0) begin
        mismatch($sformatf("unexpected item: histogram %0d macd %0d buy %0b",
                           hist, macd, buy));
      end else begin
        want = pending_results.pop_front();
        if (hist !== want.hist)
          mismatch($sformatf("histogram got %0d want %0d", hist, want.hist));
        if (macd !== want.macd)
          mismatch($sformatf("macd_value got %0d want %0d", macd, want.macd));
        if (buy !== want.buy)
          mismatch($sformatf("buy got %0b want %0b", buy, want.buy));
      end
    endtask

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [PRICE_W-1:0]       in_price;
  logic                     in_restart;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [HIST_W-1:0] out_histogram;
  logic signed [MACD_W-1:0] out_macd_value;
  logic                     out_buy;

  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned hold_request;

  macd_outlook outlook;

  macd_histogram_tracker_core #(
    .FAST_PERIOD  (FAST_PERIOD),
    .SLOW_PERIOD  (SLOW_PERIOD),
    .SIGNAL_PERIOD(SIGNAL_PERIOD)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_price      (in_price),
    .in_restart    (in_restart),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_histogram (out_histogram),
    .out_macd_value(out_macd_value),
    .out_buy       (out_buy)
  );

  always #10 clk = ~clk;

  // Run limit, far above the slowest legal run
  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Watch both handshakes at the edge
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (in_valid && !in_stall) outlook.take_price(in_price, in_restart);
      if (out_valid && !out_stall)
        outlook.check_result(out_histogram, out_macd_value, out_buy);
    end
  end

  // Receiver: random stall, or a long hold-off counted down here
  initial begin
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != hold_seen) begin
        hold_left = hold_request;
        hold_seen = hold_request;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Offer one item, with a random gap ahead of it; returns at the accepting edge
  task automatic send_price(input logic [PRICE_W-1:0] price, input logic restart);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid   <= 1'b1;
    in_price   <= price;
    in_restart <= restart;
    do @(posedge clk); while (in_stall);
  endtask

  // Warm-up, restart during warm-up, full-scale prices
  task automatic run_directed();
    int i;
    for (i = 0; i < 25; i++) begin
      if (i < 4) send_price((i % 2 == 0) ? 32'hFFFF_FFFF : 32'h0000_0000, i == 0);
      else if (i < 16) send_price(32'hFFFF_FFFF, i == 4);
      else send_price(32'h0000_0000, 1'b0);
    end
  endtask

  // Runs of prices; most are long enough to reach the histogram and saturate
  // the sample count, a few are cut short during warm-up
  task automatic run_stream(input int n_items);
    int           sent;
    int           run_len;
    int           i;
    price_style_t style;
    longint       level;
    longint       drift;
    logic         restart;
    sent = 0;
    while (sent < n_items) begin
      run_len = ($urandom_range(9) == 0) ? $urandom_range(1, 40) : $urandom_range(35, 140);
      style   = price_style_t'($urandom_range(3));
      level   = $urandom;
      drift   = longint'($urandom_range(0, 1 << 20)) - (1 << 19);
      for (i = 0; i < run_len && sent < n_items; i++) begin
        case (style)
          STYLE_SCATTER: level = $urandom;
          STYLE_WALK:    level += longint'($urandom_range(0, 1 << 22)) - (1 << 21);
          STYLE_EXTREME: level = $urandom_range(1) ? PRICE_TOP : 0;
          default:       level += drift + longint'($urandom_range(0, 1 << 18)) - (1 << 17);
        endcase
        if (level < 0) level = 0;
        if (level > PRICE_TOP) level = PRICE_TOP;
        // Most runs begin with a restart; some carry on the previous stream
        restart = (i == 0) && ($urandom_range(7) != 0);
        send_price(level[PRICE_W-1:0], restart);
        sent++;
      end
    end
  endtask

  // Main sequence
  initial begin
    int phase;
    outlook       = new();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_price      = '0;
    in_restart    = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_request  = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    // Phases: no idling, sender idle, receiver stall, both, long hold-off
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 61; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 61; end
        3: begin send_idle_pct = 18; stall_pct = 18; end
        default: begin
          send_idle_pct = 0;
          stall_pct     = 0;
          hold_request  = 400;
        end
      endcase
      run_stream(365);
    end
    in_valid  <= 1'b0;
    stall_pct = 0;

    // Drain, then allow a full program length for anything stray
    while (outlook.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (outlook.pending() != 0)
      outlook.mismatch($sformatf("%0d items never delivered", outlook.pending()));
    if (outlook.fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
